// ----- hdl/sgsd_pkg.sv -----
// Shared types, codes, register indexes and the gesture pattern table
// for the stick gesture sequence detector. No dependencies.
`default_nettype none

package sgsd_pkg;

    localparam int SEQ_LEN      = 7;
    localparam int NUM_PATTERNS = 18;
    localparam int TUNE_FIRST   = 4;
    localparam int TUNE_LAST    = 7;

    localparam int STICK_W = 12;
    localparam int THR_W   = 11;
    localparam int TIME_W  = 32;
    localparam int CMD_W   = 5;
    localparam int GEST_W  = 3;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    typedef logic [GEST_W-1:0]               gest_t;
    typedef logic [SEQ_LEN-1:0][GEST_W-1:0]  hist_t;
    typedef logic [CMD_W-1:0]                cmd_t;

    localparam gest_t G_CENTER = 3'd0;
    localparam gest_t G_LEFT   = 3'd1;
    localparam gest_t G_RIGHT  = 3'd2;
    localparam gest_t G_DOWN   = 3'd3;
    localparam gest_t G_UP     = 3'd4;
    localparam gest_t G_IDLE   = 3'd5;
    localparam gest_t G_OTHER  = 3'd6;
    localparam gest_t G_LONG   = 3'd7;

    localparam cmd_t CMD_NONE = 5'd0;

    localparam logic [IDX_W-1:0] REG_FAR    = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER = 3'd1;
    localparam logic [IDX_W-1:0] REG_HMIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_HLONG  = 3'd3;
    localparam logic [IDX_W-1:0] REG_IDLE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_TUNE   = 3'd5;

    localparam logic [THR_W-1:0]  FAR_RST    = 11'd717;
    localparam logic [THR_W-1:0]  CENTER_RST = 11'd205;
    localparam logic [TIME_W-1:0] HMIN_RST   = 32'd100000;
    localparam logic [TIME_W-1:0] HLONG_RST  = 32'd500000;
    localparam logic [TIME_W-1:0] IDLE_RST   = 32'd700000;

    // oldest entry first; pattern k gives command k+1
    localparam gest_t PATTERNS [NUM_PATTERNS][SEQ_LEN] = '{
        '{G_IDLE, G_LEFT,  G_CENTER, G_LEFT,  G_CENTER, G_DOWN,  G_CENTER},
        '{G_IDLE, G_RIGHT, G_CENTER, G_RIGHT, G_CENTER, G_DOWN,  G_CENTER},
        '{G_IDLE, G_DOWN,  G_CENTER, G_DOWN,  G_CENTER, G_DOWN,  G_CENTER},
        '{G_IDLE, G_UP,    G_CENTER, G_UP,    G_CENTER, G_UP,    G_CENTER},
        '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_UP,    G_CENTER},
        '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_DOWN,  G_CENTER},
        '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_RIGHT, G_CENTER},
        '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_LEFT,  G_CENTER},
        '{G_IDLE, G_LEFT,  G_CENTER, G_DOWN,  G_CENTER, G_DOWN,  G_CENTER},
        '{G_IDLE, G_RIGHT, G_CENTER, G_DOWN,  G_CENTER, G_DOWN,  G_CENTER},
        '{G_IDLE, G_LEFT,  G_CENTER, G_UP,    G_CENTER, G_UP,    G_CENTER},
        '{G_IDLE, G_RIGHT, G_CENTER, G_UP,    G_CENTER, G_UP,    G_CENTER},
        '{G_IDLE, G_LEFT,  G_CENTER, G_LEFT,  G_CENTER, G_LEFT,  G_CENTER},
        '{G_IDLE, G_RIGHT, G_CENTER, G_RIGHT, G_CENTER, G_RIGHT, G_CENTER},
        '{G_IDLE, G_LEFT,  G_CENTER, G_LEFT,  G_CENTER, G_RIGHT, G_CENTER},
        '{G_IDLE, G_RIGHT, G_CENTER, G_RIGHT, G_CENTER, G_LEFT,  G_CENTER},
        '{G_IDLE, G_RIGHT, G_CENTER, G_LEFT,  G_CENTER, G_LEFT,  G_CENTER},
        '{G_IDLE, G_LEFT,  G_CENTER, G_RIGHT, G_CENTER, G_RIGHT, G_CENTER}
    };

endpackage

`default_nettype wire

// ----- hdl/sgsd_classify.sv -----
// Stick sample classifier: center, left, right, down, up by priority,
// keeping the previous class when none fits. Uses sgsd_pkg.
`default_nettype none

module sgsd_classify
(
    input  wire logic signed [sgsd_pkg::STICK_W-1:0] roll,
    input  wire logic signed [sgsd_pkg::STICK_W-1:0] pitch,
    input  wire logic signed [sgsd_pkg::STICK_W-1:0] yaw,
    input  wire logic        [sgsd_pkg::THR_W-1:0]   far_thr,
    input  wire logic        [sgsd_pkg::THR_W-1:0]   center_thr,
    input  wire sgsd_pkg::gest_t                     cur_class,
    output sgsd_pkg::gest_t                          new_class
);

    localparam int EXT_W = sgsd_pkg::STICK_W + 1;

    logic signed [EXT_W-1:0] far_pos;
    logic signed [EXT_W-1:0] far_neg;
    logic        [sgsd_pkg::STICK_W-1:0] roll_mag;
    logic        [sgsd_pkg::STICK_W-1:0] pitch_mag;
    logic        [sgsd_pkg::STICK_W-1:0] yaw_mag;
    logic        [sgsd_pkg::STICK_W-1:0] center_ext;
    logic roll_c, pitch_c, yaw_c, xc;
    logic roll_hi, roll_lo, pitch_hi, pitch_lo, yaw_hi, yaw_lo;

    assign far_pos    = $signed({2'b00, far_thr});
    assign far_neg    = -far_pos;
    assign center_ext = {1'b0, center_thr};

    assign roll_mag  = roll[sgsd_pkg::STICK_W-1]  ? (~roll + 1'b1)  : roll;
    assign pitch_mag = pitch[sgsd_pkg::STICK_W-1] ? (~pitch + 1'b1) : pitch;
    assign yaw_mag   = yaw[sgsd_pkg::STICK_W-1]   ? (~yaw + 1'b1)   : yaw;

    assign roll_c  = roll_mag < center_ext;
    assign pitch_c = pitch_mag < center_ext;
    assign yaw_c   = yaw_mag < center_ext;
    assign xc      = roll_c && yaw_c;

    assign roll_hi  = EXT_W'(roll)  >= far_pos;
    assign roll_lo  = EXT_W'(roll)  <= far_neg;
    assign pitch_hi = EXT_W'(pitch) >= far_pos;
    assign pitch_lo = EXT_W'(pitch) <= far_neg;
    assign yaw_hi   = EXT_W'(yaw)   >= far_pos;
    assign yaw_lo   = EXT_W'(yaw)   <= far_neg;

    always_comb
    begin
        if (xc && pitch_c)
        begin
            new_class = sgsd_pkg::G_CENTER;
        end
        else if ((roll_lo || yaw_lo) && pitch_c)
        begin
            new_class = sgsd_pkg::G_LEFT;
        end
        else if ((roll_hi || yaw_hi) && pitch_c)
        begin
            new_class = sgsd_pkg::G_RIGHT;
        end
        else if (pitch_lo && xc)
        begin
            new_class = sgsd_pkg::G_DOWN;
        end
        else if (pitch_hi && xc)
        begin
            new_class = sgsd_pkg::G_UP;
        end
        else
        begin
            new_class = cur_class;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sgsd_match.sv -----
// Parallel match of the gesture history against the pattern table with
// first-match priority. Uses sgsd_pkg.
`default_nettype none

module sgsd_match
(
    input  wire sgsd_pkg::hist_t hist,
    input  wire logic            tuning_en,
    output sgsd_pkg::cmd_t       cmd
);

    logic [sgsd_pkg::NUM_PATTERNS-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < sgsd_pkg::NUM_PATTERNS; k++)
        begin
            hit[k] = 1'b1;
            for (int i = 0; i < sgsd_pkg::SEQ_LEN; i++)
            begin
                if (hist[i] != sgsd_pkg::PATTERNS[k][sgsd_pkg::SEQ_LEN-1-i])
                begin
                    hit[k] = 1'b0;
                end
            end
            if (k >= sgsd_pkg::TUNE_FIRST && k <= sgsd_pkg::TUNE_LAST && !tuning_en)
            begin
                hit[k] = 1'b0;
            end
        end
    end

    always_comb
    begin
        cmd = sgsd_pkg::CMD_NONE;
        for (int k = sgsd_pkg::NUM_PATTERNS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                cmd = sgsd_pkg::CMD_W'(k + 1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/stick_gesture_sequence_detector.sv -----
// Top level of the stick gesture sequence detector: input register, hold
// timing, history and result register. Uses sgsd_pkg, sgsd_classify, sgsd_match.
//
//   port group   dir  transfer
//   in_*         in   valid/ready, one stick sample per transaction
//   out_*        out  valid/ready, one command/held gesture per transaction
//   cfg_*        in   write enable, index, data; no wait, no read-back
//
// One sample per cycle while out_ready is high; input reg, then result reg.
// The rate is set by the single state update (class, hold timer, history) per cycle.
// Reset clears valid flags and gesture state and loads default thresholds and times.
// A stalled result holds the register stage; the input side keeps accepting
// while the input register is free.
`default_nettype none

module stick_gesture_sequence_detector
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [sgsd_pkg::STICK_W-1:0] roll_stick,
    input  wire logic signed [sgsd_pkg::STICK_W-1:0] pitch_stick,
    input  wire logic signed [sgsd_pkg::STICK_W-1:0] yaw_stick,
    input  wire logic                                on_ground,
    input  wire logic        [sgsd_pkg::TIME_W-1:0]  time_us,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic             [sgsd_pkg::CMD_W-1:0]   command,
    output logic             [sgsd_pkg::GEST_W-1:0]  held_gesture,
    input  wire logic                                cfg_we,
    input  wire logic        [sgsd_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic        [sgsd_pkg::DATA_W-1:0]  cfg_data
);

    logic [sgsd_pkg::THR_W-1:0]  far_reg;
    logic [sgsd_pkg::THR_W-1:0]  center_reg;
    logic [sgsd_pkg::TIME_W-1:0] hmin_reg;
    logic [sgsd_pkg::TIME_W-1:0] hlong_reg;
    logic [sgsd_pkg::TIME_W-1:0] idle_reg;
    logic                        tune_reg;

    logic                                s1_valid_reg;
    logic signed [sgsd_pkg::STICK_W-1:0] roll_reg;
    logic signed [sgsd_pkg::STICK_W-1:0] pitch_reg;
    logic signed [sgsd_pkg::STICK_W-1:0] yaw_reg;
    logic                                ground_reg;
    logic        [sgsd_pkg::TIME_W-1:0]  time_reg;

    sgsd_pkg::gest_t               class_reg, class_next;
    sgsd_pkg::gest_t               prev_reg, prev_next;
    sgsd_pkg::gest_t               held_reg, held_next;
    logic [sgsd_pkg::TIME_W-1:0]   change_reg, change_next;
    sgsd_pkg::hist_t               hist_reg, hist_next;

    logic           out_valid_reg;
    sgsd_pkg::cmd_t command_reg, command_next;

    sgsd_pkg::gest_t             cls;
    sgsd_pkg::hist_t             pushed;
    sgsd_pkg::cmd_t              match_cmd;
    logic [sgsd_pkg::TIME_W-1:0] elapsed;
    logic                        adv;

    assign adv          = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready     = !s1_valid_reg || adv;
    assign out_valid    = out_valid_reg;
    assign command      = command_reg;
    assign held_gesture = held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_reg    <= sgsd_pkg::FAR_RST;
            center_reg <= sgsd_pkg::CENTER_RST;
            hmin_reg   <= sgsd_pkg::HMIN_RST;
            hlong_reg  <= sgsd_pkg::HLONG_RST;
            idle_reg   <= sgsd_pkg::IDLE_RST;
            tune_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sgsd_pkg::REG_FAR:    far_reg    <= cfg_data[sgsd_pkg::THR_W-1:0];
                sgsd_pkg::REG_CENTER: center_reg <= cfg_data[sgsd_pkg::THR_W-1:0];
                sgsd_pkg::REG_HMIN:   hmin_reg   <= cfg_data;
                sgsd_pkg::REG_HLONG:  hlong_reg  <= cfg_data;
                sgsd_pkg::REG_IDLE:   idle_reg   <= cfg_data;
                sgsd_pkg::REG_TUNE:   tune_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            roll_reg   <= roll_stick;
            pitch_reg  <= pitch_stick;
            yaw_reg    <= yaw_stick;
            ground_reg <= on_ground;
            time_reg   <= time_us;
        end
    end

    sgsd_classify u_classify
    (
        .roll       (roll_reg),
        .pitch      (pitch_reg),
        .yaw        (yaw_reg),
        .far_thr    (far_reg),
        .center_thr (center_reg),
        .cur_class  (class_reg),
        .new_class  (cls)
    );

    assign pushed = {hist_reg[sgsd_pkg::SEQ_LEN-2:0], held_next};

    sgsd_match u_match
    (
        .hist      (pushed),
        .tuning_en (tune_reg),
        .cmd       (match_cmd)
    );

    always_comb
    begin
        class_next   = class_reg;
        prev_next    = sgsd_pkg::G_OTHER;
        held_next    = sgsd_pkg::G_OTHER;
        change_next  = change_reg;
        hist_next    = hist_reg;
        command_next = sgsd_pkg::CMD_NONE;
        elapsed      = '0;
        if (ground_reg)
        begin
            class_next  = cls;
            prev_next   = cls;
            change_next = (cls != prev_reg) ? time_reg : change_reg;
            elapsed     = time_reg - change_next;
            held_next   = held_reg;
            if (elapsed > hmin_reg)
            begin
                if (cls == sgsd_pkg::G_CENTER && elapsed > idle_reg)
                begin
                    held_next = sgsd_pkg::G_IDLE;
                end
                else if (elapsed > hlong_reg)
                begin
                    held_next = sgsd_pkg::G_LONG;
                end
                else
                begin
                    held_next = cls;
                end
            end
            if (held_next != hist_reg[0])
            begin
                hist_next    = pushed;
                command_next = match_cmd;
                if (match_cmd != sgsd_pkg::CMD_NONE)
                begin
                    hist_next[1] = sgsd_pkg::G_OTHER;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg     <= sgsd_pkg::G_CENTER;
            prev_reg      <= sgsd_pkg::G_CENTER;
            held_reg      <= sgsd_pkg::G_CENTER;
            change_reg    <= '0;
            hist_reg      <= '0;
            out_valid_reg <= 1'b0;
            command_reg   <= sgsd_pkg::CMD_NONE;
        end
        else
        begin
            if (adv)
            begin
                class_reg   <= class_next;
                prev_reg    <= prev_next;
                held_reg    <= held_next;
                change_reg  <= change_next;
                hist_reg    <= hist_next;
                command_reg <= command_next;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_cmd_ends_center: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command != sgsd_pkg::CMD_NONE |-> held_gesture == sgsd_pkg::G_CENTER)
        else $error("command issued without a center held gesture");

    a_match_marks_other: assert property (@(posedge clk) disable iff (!rst_n)
        adv && command_next != sgsd_pkg::CMD_NONE |=> hist_reg[1] == sgsd_pkg::G_OTHER)
        else $error("history entry one not marked after a match");

    a_tuning_gated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tune_reg |-> command <= sgsd_pkg::cmd_t'(sgsd_pkg::TUNE_FIRST)
            || command > sgsd_pkg::cmd_t'(sgsd_pkg::TUNE_LAST + 1))
        else $error("tuning command issued while tuning is disabled");

    a_off_ground: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !ground_reg |=> held_reg == sgsd_pkg::G_OTHER
            && command_reg == sgsd_pkg::CMD_NONE)
        else $error("off-ground sample produced a gesture or command");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for stick_gesture_sequence_detector: drives stick samples and
// register writes, tracks the gesture state alongside and checks every command/held gesture.
// Depends on sgsd_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

import sgsd_pkg::*;

typedef struct packed {
    cmd_t  cmd;
    gest_t gest;
} gesture_result_t;

class gesture_tracker;
    logic [THR_W-1:0]  far_thr;
    logic [THR_W-1:0]  center_thr;
    logic [TIME_W-1:0] hold_min;
    logic [TIME_W-1:0] hold_long;
    logic [TIME_W-1:0] idle_time;
    bit                tune_on;

    gest_t             cur_class;
    gest_t             last_class;
    gest_t             held;
    logic [TIME_W-1:0] change_stamp;
    gest_t             hist [SEQ_LEN];

    // letters of each command between the leading idle and the center gaps
    gest_t             letters [NUM_PATTERNS][3];
    gesture_result_t   command_queue [$];
    int                errors;

    function new();
        far_thr      = FAR_RST;
        center_thr   = CENTER_RST;
        hold_min     = HMIN_RST;
        hold_long    = HLONG_RST;
        idle_time    = IDLE_RST;
        tune_on      = 1'b0;
        cur_class    = G_CENTER;
        last_class   = G_CENTER;
        held         = G_CENTER;
        change_stamp = '0;
        errors       = 0;
        foreach (hist[i])
        begin
            hist[i] = G_CENTER;
        end
        letters = '{
            '{G_LEFT,  G_LEFT,  G_DOWN},  '{G_RIGHT, G_RIGHT, G_DOWN},
            '{G_DOWN,  G_DOWN,  G_DOWN},  '{G_UP,    G_UP,    G_UP},
            '{G_UP,    G_DOWN,  G_UP},    '{G_UP,    G_DOWN,  G_DOWN},
            '{G_UP,    G_DOWN,  G_RIGHT}, '{G_UP,    G_DOWN,  G_LEFT},
            '{G_LEFT,  G_DOWN,  G_DOWN},  '{G_RIGHT, G_DOWN,  G_DOWN},
            '{G_LEFT,  G_UP,    G_UP},    '{G_RIGHT, G_UP,    G_UP},
            '{G_LEFT,  G_LEFT,  G_LEFT},  '{G_RIGHT, G_RIGHT, G_RIGHT},
            '{G_LEFT,  G_LEFT,  G_RIGHT}, '{G_RIGHT, G_RIGHT, G_LEFT},
            '{G_RIGHT, G_LEFT,  G_LEFT},  '{G_LEFT,  G_RIGHT, G_RIGHT}
        };
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        case (idx)
            REG_FAR:    far_thr    = data[THR_W-1:0];
            REG_CENTER: center_thr = data[THR_W-1:0];
            REG_HMIN:   hold_min   = data;
            REG_HLONG:  hold_long  = data;
            REG_IDLE:   idle_time  = data;
            REG_TUNE:   tune_on    = data[0];
            default:    ;
        endcase
    endfunction

    function bit centered(int v);
        int m;
        m = (v < 0) ? -v : v;
        return m < int'(center_thr);
    endfunction

    function bit far_high(int v);
        return v >= int'(far_thr);
    endfunction

    function bit far_low(int v);
        return v <= -int'(far_thr);
    endfunction

    function cmd_t shift_history(gest_t g);
        if (g == hist[0])
            return CMD_NONE;
        for (int i = SEQ_LEN - 1; i >= 1; i--)
            hist[i] = hist[i-1];
        hist[0] = g;
        for (int k = 0; k < NUM_PATTERNS; k++)
        begin
            if (k >= TUNE_FIRST && k <= TUNE_LAST && !tune_on)
                continue;
            if (hist[6] == G_IDLE && hist[5] == letters[k][0] && hist[4] == G_CENTER &&
                hist[3] == letters[k][1] && hist[2] == G_CENTER &&
                hist[1] == letters[k][2] && hist[0] == G_CENTER)
            begin
                hist[1] = G_OTHER;
                return cmd_t'(k + 1);
            end
        end
        return CMD_NONE;
    endfunction

    function void take_sample(logic signed [STICK_W-1:0] roll, logic signed [STICK_W-1:0] pitch,
                              logic signed [STICK_W-1:0] yaw, logic ground,
                              logic [TIME_W-1:0] now);
        int                r;
        int                p;
        int                y;
        bit                xc;
        bit                pc;
        logic [TIME_W-1:0] elapsed;
        gesture_result_t   res;
        res.cmd = CMD_NONE;
        if (ground)
        begin
            r  = int'(roll);
            p  = int'(pitch);
            y  = int'(yaw);
            xc = centered(r) && centered(y);
            pc = centered(p);
            if (xc && pc)
                cur_class = G_CENTER;
            else if ((far_low(r) || far_low(y)) && pc)
                cur_class = G_LEFT;
            else if ((far_high(r) || far_high(y)) && pc)
                cur_class = G_RIGHT;
            else if (far_low(p) && xc)
                cur_class = G_DOWN;
            else if (far_high(p) && xc)
                cur_class = G_UP;
            if (cur_class != last_class)
                change_stamp = now;
            elapsed = now - change_stamp;
            if (elapsed > hold_min)
            begin
                if (cur_class == G_CENTER && elapsed > idle_time)
                    held = G_IDLE;
                else if (elapsed > hold_long)
                    held = G_LONG;
                else
                    held = cur_class;
            end
            last_class = cur_class;
            res.cmd = shift_history(held);
        end
        else
        begin
            held       = G_OTHER;
            last_class = G_OTHER;
        end
        res.gest = held;
        command_queue.push_back(res);
    endfunction

    function void check_result(cmd_t cmd, gest_t gest);
        gesture_result_t want;
        if (command_queue.size() == 0)
        begin
            $error("result with nothing outstanding: command %0d held_gesture %0d", cmd, gest);
            errors++;
            return;
        end
        want = command_queue.pop_front();
        if (cmd !== want.cmd)
        begin
            $error("command mismatch: expected %0d, actual %0d", want.cmd, cmd);
            errors++;
        end
        if (gest !== want.gest)
        begin
            $error("held_gesture mismatch: expected %0d, actual %0d", want.gest, gest);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int PHASE_ITEMS    = 150;
    localparam int HOLD_OFF       = 300;

    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic signed [STICK_W-1:0]  roll_stick  = '0;
    logic signed [STICK_W-1:0]  pitch_stick = '0;
    logic signed [STICK_W-1:0]  yaw_stick   = '0;
    logic                       on_ground   = 1'b0;
    logic        [TIME_W-1:0]   time_us     = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic        [CMD_W-1:0]    command;
    logic        [GEST_W-1:0]   held_gesture;
    logic                       cfg_we      = 1'b0;
    logic        [IDX_W-1:0]    cfg_index   = '0;
    logic        [DATA_W-1:0]   cfg_data    = '0;

    gesture_tracker    tracker = new();
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_off_req  = 0;
    int                hold_off_left = 0;
    int                items_sent    = 0;
    int                gesture_idx   = 0;
    logic [TIME_W-1:0] now_us        = '0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    stick_gesture_sequence_detector i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .roll_stick   (roll_stick),
        .pitch_stick  (pitch_stick),
        .yaw_stick    (yaw_stick),
        .on_ground    (on_ground),
        .time_us      (time_us),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command      (command),
        .held_gesture (held_gesture),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    task automatic send_sample(logic signed [STICK_W-1:0] r, logic signed [STICK_W-1:0] p,
                               logic signed [STICK_W-1:0] y, logic g, logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        roll_stick  <= r;
        pitch_stick <= p;
        yaw_stick   <= y;
        on_ground   <= g;
        time_us     <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_sample(r, p, y, g, t);
        items_sent++;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.set_register(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(int far, int center, logic [TIME_W-1:0] hmin,
                                  logic [TIME_W-1:0] hlong, logic [TIME_W-1:0] idle, bit tune);
        write_reg(REG_FAR, far);
        write_reg(REG_CENTER, center);
        write_reg(REG_HMIN, hmin);
        write_reg(REG_HLONG, hlong);
        write_reg(REG_IDLE, idle);
        write_reg(REG_TUNE, DATA_W'(tune));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.command_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic signed [STICK_W-1:0] centered_val();
        int c;
        c = int'(tracker.center_thr);
        if (c == 0)
            return '0;
        if (c > 1024)
            c = 1024;
        return STICK_W'($urandom_range(2 * (c - 1)) - (c - 1));
    endfunction

    function automatic logic signed [STICK_W-1:0] far_val(bit neg);
        int f;
        int v;
        f = int'(tracker.far_thr);
        if (f > 1024)
            f = 1024;
        v = $urandom_range(1024, f);
        return neg ? STICK_W'(-v) : STICK_W'(v);
    endfunction

    function automatic logic signed [STICK_W-1:0] rand_stick();
        return STICK_W'($urandom_range(2048) - 1024);
    endfunction

    function automatic logic [TIME_W-1:0] window_pick(logic [TIME_W-1:0] lo,
                                                      logic [TIME_W-1:0] hi);
        longint span;
        span = longint'(hi) - longint'(lo);
        if (span <= 0)
            return lo + 1;
        if (span > 200000)
            span = 200000;
        return lo + 1 + $urandom_range(32'(span - 1));
    endfunction

    task automatic send_class(gest_t cls, logic [TIME_W-1:0] t);
        logic signed [STICK_W-1:0] r;
        logic signed [STICK_W-1:0] p;
        logic signed [STICK_W-1:0] y;
        bit                        on_yaw;
        r      = centered_val();
        p      = centered_val();
        y      = centered_val();
        on_yaw = 1'($urandom_range(1));
        case (cls)
            G_LEFT:  if (on_yaw) y = far_val(1'b1); else r = far_val(1'b1);
            G_RIGHT: if (on_yaw) y = far_val(1'b0); else r = far_val(1'b0);
            G_DOWN:  p = far_val(1'b1);
            G_UP:    p = far_val(1'b0);
            default: ;
        endcase
        send_sample(r, p, y, 1'b1, t);
    endtask

    // hold one class for a given time, with up to two samples in between
    task automatic hold_class(gest_t cls, logic [TIME_W-1:0] hold);
        logic [TIME_W-1:0] start;
        start = now_us;
        send_class(cls, start);
        repeat ($urandom_range(2))
        begin
            if ($urandom_range(3) == 0)
                send_sample(far_val(1'b0), far_val(1'b0), centered_val(), 1'b1,
                            start + $urandom_range(hold));
            else
                send_class(cls, start + $urandom_range(hold));
        end
        send_class(cls, start + hold);
        now_us = start + hold + $urandom_range(2000, 1);
    endtask

    task automatic run_gesture(int k, bit broken);
        int                bad_step;
        bit                short_hold;
        gest_t             letter;
        logic [TIME_W-1:0] tmin;
        logic [TIME_W-1:0] mid_top;
        logic [TIME_W-1:0] dir_hold;
        bad_step   = broken ? $urandom_range(2) : 3;
        short_hold = 1'($urandom_range(1));
        tmin       = tracker.hold_min;
        mid_top    = (tracker.idle_time < tracker.hold_long) ? tracker.idle_time
                                                             : tracker.hold_long;
        hold_class(G_CENTER, tracker.idle_time + 1 + $urandom_range(5000));
        for (int j = 0; j < 3; j++)
        begin
            letter   = tracker.letters[k][j];
            dir_hold = window_pick(tmin, tracker.hold_long);
            if (j == bad_step)
            begin
                if (short_hold)
                    dir_hold = tmin;
                else
                    letter = gest_t'($urandom_range(G_UP, G_LEFT));
            end
            hold_class(letter, dir_hold);
            hold_class(G_CENTER, window_pick(tmin, mid_top));
        end
    endtask

    task automatic send_noise();
        logic ground;
        ground = ($urandom_range(9) != 0);
        if ($urandom_range(4) == 0)
            now_us = $urandom();
        else
            now_us = now_us + $urandom_range(300000);
        send_sample(rand_stick(), rand_stick(), rand_stick(), ground, now_us);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.check_result(command, held_gesture);
            if (hold_off_req > 0)
            begin
                hold_off_left = hold_off_req;
                hold_off_req  = 0;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("stick_gesture_sequence_detector test failed");
        $finish;
    end

    initial
    begin
        int stop_at;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 21;
        recv_idle_pct = 65;
        send_sample(12'sd0, 12'sd0, 12'sd0, 1'b1, 32'd0);
        send_sample(-12'sd1024, 12'sd0, 12'sd0, 1'b1, 32'd10);
        send_sample(12'sd0, 12'sd0, 12'sd1024, 1'b1, 32'd20);
        send_sample(12'sd0, -12'sd1024, 12'sd0, 1'b1, 32'd30);
        send_sample(12'sd0, 12'sd1024, 12'sd0, 1'b1, 32'd40);
        send_sample(12'sd0, 12'sd1024, 12'sd0, 1'b1, 32'd100041);
        send_sample(12'sd0, 12'sd1024, 12'sd0, 1'b1, 32'd600050);
        send_sample(12'sd717, 12'sd0, 12'sd0, 1'b1, 32'd600060);
        send_sample(12'sd716, 12'sd0, 12'sd0, 1'b1, 32'd700061);
        send_sample(12'sd204, 12'sd0, -12'sd204, 1'b1, 32'd700070);
        send_sample(12'sd205, 12'sd0, 12'sd0, 1'b1, 32'd800071);
        send_sample(12'sd0, 12'sd0, -12'sd717, 1'b1, 32'd800080);
        send_sample(12'sd1024, 12'sd1024, -12'sd1024, 1'b0, 32'hFFFF_FFFF);
        send_sample(12'sd0, 12'sd0, 12'sd0, 1'b1, 32'hFFFF_FFF0);
        send_sample(12'sd0, 12'sd0, 12'sd0, 1'b1, 32'h000F_0000);
        send_sample(12'sd0, -12'sd204, 12'sd0, 1'b1, 32'h000F_0010);
        send_sample(12'sd1024, -12'sd1024, 12'sd1024, 1'b1, 32'h0010_0000);
        send_sample(-12'sd1024, -12'sd1024, -12'sd1024, 1'b1, 32'h0020_0000);
        send_sample(12'sd0, 12'sd0, 12'sd0, 1'b0, 32'h0030_0000);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            send_idle_pct = (phase < 2) ? 21 : (phase < 4) ? 65 : 0;
            recv_idle_pct = (phase < 2) ? 65 : (phase < 4) ? 21 : 0;
            drain();
            case (phase)
                0: apply_settings(717, 205, 32'd2000, 32'd9000, 32'd12000, 1'b1);
                1: apply_settings(1024, 1024, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
                2: apply_settings(0, 0, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1);
                default:
                begin
                    apply_settings($urandom_range(1024, 400), $urandom_range(399),
                                   $urandom_range(50000), 32'd0, 32'd0,
                                   1'($urandom_range(1)));
                    write_reg(REG_HLONG, tracker.hold_min + $urandom_range(100000, 1));
                    write_reg(REG_IDLE, tracker.hold_min + $urandom_range(300000, 1));
                end
            endcase
            // writes to unused indexes must leave every register alone
            write_reg(REG_SPARE_LO, $urandom());
            write_reg(REG_SPARE_HI, $urandom());
            now_us = (phase == 3) ? 32'hFFFF_0000 : $urandom();
            if (phase == 4)
                hold_off_req = HOLD_OFF;
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at)
            begin
                if ($urandom_range(3) != 0)
                begin
                    run_gesture(gesture_idx % NUM_PATTERNS, $urandom_range(9) == 0);
                    gesture_idx++;
                end
                else
                begin
                    repeat ($urandom_range(4, 1)) send_noise();
                end
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
            $display("stick_gesture_sequence_detector test passed");
        else
            $display("stick_gesture_sequence_detector test failed");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/sgsd_pkg.sv
hdl/sgsd_classify.sv
hdl/sgsd_match.sv
hdl/stick_gesture_sequence_detector.sv
verif/tb.sv
